FILE: rtl/hbws_pkg.sv
// ----------------------------------------------------------------------------
// hbws_pkg
// shared constants and helpers for the huffman bit writer with byte stuffing
// ----------------------------------------------------------------------------
package hbws_pkg;

  // parameter defaults
  localparam int DEF_NUM_TABLES   = 2;
  localparam int DEF_MAX_CATEGORY = 16;

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;

  // request kinds
  localparam logic [1:0] REQ_ENCODE = 2'd0;
  localparam logic [1:0] REQ_FLUSH  = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  // table entry: code in [20:5], length in [4:0]
  localparam int ENTRY_W  = 21;
  localparam int CODE_W   = 16;
  localparam int LEN_W    = 5;
  localparam logic [LEN_W-1:0] MAX_CODE_LEN = 5'd16;

  // category that carries no extra bits besides zero
  localparam logic [4:0] CAT_NO_EXTRA = 5'd16;

  // merge word: 7 pending bits + 16 code bits + 15 extra bits
  localparam int ACC_W  = 38;
  localparam int WORD_W = 32;

  localparam logic [7:0] BYTE_FF    = 8'hFF;
  localparam logic [7:0] STUFF_BYTE = 8'h00;

  // bit length of a 17-bit magnitude
  function automatic logic [4:0] cat_of(input logic [16:0] mag);
    logic [4:0] c;
    c = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (mag[i]) c = 5'(i + 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/huffman_bit_writer_stuffing.sv
// ----------------------------------------------------------------------------
// huffman_bit_writer_stuffing
// lossless jpeg entropy bit writer: huffman code plus extra bits, msb first,
// 0x00 stuffed after every 0xff, flush pads the partial byte with ones
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                  | tuser            | tlast
//  --------+-----+----------------------------------------+------------------+----------
//  in_     | in  | diff_value, entry_index, entry_code,   | req_type,        | -
//          |     | entry_len (48 bits, zero padded)       | table_sel        |
//  out_    | out | byte_out                               | -                | last_byte
//
//  flow: stage 0 classifies the item and reads the code table memory,
//  stage 1 merges code and extra bits with the pending bits, the byte
//  emitter then sends one byte per cycle while out_tready is high (0..4 data
//  bytes plus stuffing, up to 8 per item). loads, empty flushes and unused
//  kinds emit no bytes. sustained rate is set by the one-byte output; an
//  accepted item is registered into stage 1, then into the emitter, whose
//  register drives the first byte.
//  reset: synchronous active low, clears pending bits and all valid flags;
//  the code table is undefined until loaded.
//  stalls: a held output keeps the emitter, stage 1 holds an item with bytes
//  while the emitter is busy, and in_tready drops only when stage 1 cannot advance.
//
module huffman_bit_writer_stuffing #(
  parameter int NUM_TABLES   = hbws_pkg::DEF_NUM_TABLES,
  parameter int MAX_CATEGORY = hbws_pkg::DEF_MAX_CATEGORY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [16:0] diff_value, [21:17] entry_index, [37:22] entry_code,
  // [42:38] entry_len, [47:43] zero
  input  logic [hbws_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type, [2] table_sel
  input  logic [hbws_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] byte_out
  output logic [hbws_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  import hbws_pkg::*;

  localparam int ENTRIES = MAX_CATEGORY + 1;
  localparam int DEPTH   = NUM_TABLES * ENTRIES;
  localparam int ADDR_W  = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // input field unpack
  // ---------------------------------------------------------------------------
  logic [1:0]        in_req;
  logic              in_sel;
  logic [16:0]       in_diff;
  logic [4:0]        in_idx;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic              in_fire;

  assign in_req  = in_tuser[1:0];
  assign in_sel  = in_tuser[2];
  assign in_diff = in_tdata[16:0];
  assign in_idx  = in_tdata[21:17];
  assign in_code = in_tdata[37:22];
  assign in_len  = in_tdata[42:38];
  assign in_fire = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // stage 0: classify, address the table
  // ---------------------------------------------------------------------------
  logic              neg;
  logic [16:0]       mag;
  logic [4:0]        cat_raw;
  logic [4:0]        cat;
  logic [4:0]        xlen;
  logic [16:0]       xval;
  logic [16:0]       xmask;
  logic [15:0]       extra;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  ld_len;
  logic [16:0]       ld_mask;
  logic [CODE_W-1:0] ld_code;
  logic              ld_ok;

  always_comb begin
    neg     = in_diff[16];
    mag     = neg ? (~in_diff + 17'd1) : in_diff;
    cat_raw = cat_of(mag);
    cat     = (cat_raw > 5'(MAX_CATEGORY)) ? 5'(MAX_CATEGORY) : cat_raw;
    // category zero and the full 16-bit category carry no extra bits
    xlen    = (cat == 5'd0 || cat == CAT_NO_EXTRA) ? 5'd0 : cat;
    xval    = neg ? (in_diff - 17'd1) : in_diff;
    xmask   = (17'd1 << xlen) - 17'd1;
    extra   = xval[15:0] & xmask[15:0];

    // tables beyond the last one fold onto the last one
    base    = (in_sel && NUM_TABLES > 1) ? ADDR_W'(ENTRIES) : '0;
    rd_addr = base + ADDR_W'(cat);
    wr_addr = base + ADDR_W'(in_idx);

    ld_len  = (in_len > MAX_CODE_LEN) ? MAX_CODE_LEN : in_len;
    ld_mask = (17'd1 << ld_len) - 17'd1;
    ld_code = in_code & ld_mask[15:0];
    ld_ok   = (in_idx <= 5'(MAX_CATEGORY));
  end

  // code table memory, one write or one registered read per cycle;
  // a load followed by an encode of the same entry sees the new value
  logic [ENTRY_W-1:0] table_mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (in_fire && in_req == REQ_LOAD && ld_ok) begin
      table_mem[wr_addr] <= {ld_code, ld_len};
    end
    if (in_fire && in_req == REQ_ENCODE) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: merge with pending bits
  // ---------------------------------------------------------------------------
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_req_r;
  logic [4:0]  s1_xlen_r;
  logic [15:0] s1_extra_r;
  logic [6:0]  pbits_r, pbits_nxt;
  logic [2:0]  pcnt_r, pcnt_nxt;

  logic [LEN_W-1:0]  clen;
  logic [CODE_W-1:0] ecode;
  logic [5:0]        sh_code;
  logic [ACC_W-1:0]  enc_acc;
  logic [5:0]        enc_n;
  logic [3:0]        pad;
  logic [7:0]        fl_ones;
  logic [7:0]        fl_byte;
  logic [ACC_W-1:0]  m_acc;
  logic [5:0]        m_n;
  logic [2:0]        m_rem;
  logic [2:0]        m_nbytes;
  logic [2:0]        m_gap;
  logic [ACC_W-1:0]  m_down;
  logic [ACC_W-1:0]  m_align;
  logic [WORD_W-1:0] m_word;
  logic [7:0]        rem_mask;

  always_comb begin
    clen    = (rd_data_r[4:0] > MAX_CODE_LEN) ? MAX_CODE_LEN : rd_data_r[4:0];
    ecode   = rd_data_r[20:5];
    sh_code = 6'(clen) + 6'(s1_xlen_r);
    enc_acc = (ACC_W'(pbits_r) << sh_code)
            | (ACC_W'(ecode) << s1_xlen_r)
            | ACC_W'(s1_extra_r);
    enc_n   = 6'(pcnt_r) + 6'(clen) + 6'(s1_xlen_r);

    // flush: fill the partial byte with ones
    pad     = 4'd8 - 4'(pcnt_r);
    fl_ones = 8'((9'd1 << pad) - 9'd1);
    fl_byte = ({1'b0, pbits_r} << pad) | fl_ones;

    if (s1_req_r == REQ_FLUSH) begin
      m_acc = ACC_W'(fl_byte);
      m_n   = (pcnt_r != 3'd0) ? 6'd8 : 6'd0;
    end else begin
      m_acc = enc_acc;
      m_n   = enc_n;
    end

    m_rem    = m_n[2:0];
    m_nbytes = m_n[5:3];
    // whole bytes left aligned so the emitter takes the top byte first
    m_gap    = 3'd4 - m_nbytes;
    m_down   = m_acc >> m_rem;
    m_align  = m_down << {m_gap, 3'b000};
    m_word   = m_align[WORD_W-1:0];
    rem_mask = (8'd1 << m_rem) - 8'd1;
  end

  // ---------------------------------------------------------------------------
  // byte emitter (output register)
  // ---------------------------------------------------------------------------
  logic              em_valid_r, em_valid_nxt;
  logic [WORD_W-1:0] em_word_r, em_word_nxt;
  logic [2:0]        em_left_r, em_left_nxt;
  logic              em_stuff_r, em_stuff_nxt;

  logic [7:0] em_cur;
  logic       em_is_ff;
  logic       out_fire;
  logic       em_free;
  logic       s1_go;

  assign em_cur     = em_word_r[WORD_W-1 -: 8];
  assign em_is_ff   = !em_stuff_r && em_cur == BYTE_FF;
  assign out_tvalid = em_valid_r;
  assign out_tdata  = em_stuff_r ? STUFF_BYTE : em_cur;
  assign out_tlast  = (em_left_r == 3'd1) && !em_is_ff;
  assign out_fire   = out_tvalid && out_tready;

  assign em_free   = !em_valid_r || (out_fire && out_tlast);
  assign s1_go     = s1_valid_r && (m_nbytes == 3'd0 || em_free);
  assign in_tready = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    pbits_nxt    = pbits_r;
    pcnt_nxt     = pcnt_r;
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
      pbits_nxt    = m_acc[6:0] & rem_mask[6:0];
      pcnt_nxt     = m_rem;
    end
    if (in_fire && (in_req == REQ_ENCODE || in_req == REQ_FLUSH)) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    em_valid_nxt = em_valid_r;
    em_word_nxt  = em_word_r;
    em_left_nxt  = em_left_r;
    em_stuff_nxt = em_stuff_r;
    if (s1_go && m_nbytes != 3'd0) begin
      em_valid_nxt = 1'b1;
      em_word_nxt  = m_word;
      em_left_nxt  = m_nbytes;
      em_stuff_nxt = 1'b0;
    end else if (out_fire) begin
      if (em_is_ff) begin
        em_stuff_nxt = 1'b1;
      end else begin
        em_stuff_nxt = 1'b0;
        em_word_nxt  = em_word_r << 8;
        em_left_nxt  = em_left_r - 3'd1;
        if (em_left_r == 3'd1) em_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pbits_r    <= '0;
      pcnt_r     <= '0;
      em_valid_r <= 1'b0;
      em_stuff_r <= 1'b0;
      em_left_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      pbits_r    <= pbits_nxt;
      pcnt_r     <= pcnt_nxt;
      em_valid_r <= em_valid_nxt;
      em_stuff_r <= em_stuff_nxt;
      em_left_r  <= em_left_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= in_req;
      s1_xlen_r  <= xlen;
      s1_extra_r <= extra;
    end
    em_word_r <= em_word_nxt;
  end

`ifndef SYNTHESIS
  // pending bits above the pending count stay clear
  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (({1'b0, pbits_r} >> pcnt_r) == 8'd0))
    else $error("pending bits above count");

  // a stuffing byte is only raised after a 0xff went out
  a_stuff_after_ff: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(em_stuff_r) |-> $past(out_tvalid && out_tready && out_tdata == BYTE_FF))
    else $error("stuffing without 0xff");

  // an active emitter holds one to four data bytes
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    em_valid_r |-> (em_left_r != 3'd0 && em_left_r <= 3'd4))
    else $error("emitter byte count out of range");

  // a blocked merge stage keeps its table read data
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(rd_data_r)))
    else $error("merge stage lost its item");
`endif

endmodule

FILE: dv/hbws_stream_checker.sv
// ----------------------------------------------------------------------------
// hbws_stream_checker
// watches both streams of the bit writer, predicts the byte stream from the
// accepted items and compares every accepted byte with the oldest prediction
// ----------------------------------------------------------------------------
module hbws_stream_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [hbws_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [hbws_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [hbws_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               bytes_waiting,
  output int                               bytes_checked,
  output int                               ff_bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import hbws_pkg::*;

  localparam int TABLES  = DEF_NUM_TABLES;
  localparam int ENTRIES = DEF_MAX_CATEGORY + 1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // bytes predicted but not yet seen on the output
  stream_byte_t expected_bytes[$];

  // own copy of the code tables and of the partial byte
  logic [CODE_W-1:0] tab_code [TABLES][ENTRIES];
  logic [LEN_W-1:0]  tab_len  [TABLES][ENTRIES];
  logic [6:0]        carry_bits;
  logic [2:0]        carry_count;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // bytes that one accepted item adds to the stream
  task automatic predict_bytes(input logic [1:0] kind, input logic sel,
                               input logic [16:0] diff, input logic [4:0] idx,
                               input logic [15:0] code, input logic [4:0] len);
    logic [63:0] acc;
    int unsigned nbits;
    int unsigned cat;
    logic        neg;
    logic [16:0] mag;
    logic [16:0] extra;
    logic [4:0]  clen;
    logic [7:0]  b;
    int          first;
    acc   = 64'(carry_bits);
    nbits = carry_count;
    first = expected_bytes.size();
    case (kind)
      REQ_LOAD: begin
        if (idx <= 5'(DEF_MAX_CATEGORY)) begin
          clen = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
          tab_len[sel][idx]  = clen;
          tab_code[sel][idx] = code & 16'((32'h1 << clen) - 1);
        end
      end
      REQ_ENCODE: begin
        neg = diff[16];
        mag = neg ? (~diff + 17'd1) : diff;
        cat = 0;
        while (cat < 17 && (mag >> cat) != 0) cat++;
        // largest negative magnitude lands in the top category
        if (cat > DEF_MAX_CATEGORY) cat = DEF_MAX_CATEGORY;
        clen  = tab_len[sel][cat];
        acc   = (acc << clen) | 64'(tab_code[sel][cat]);
        nbits += clen;
        if (cat != 0 && cat != 16) begin
          extra = (neg ? diff - 17'd1 : diff) & ((17'h1 << cat) - 17'd1);
          acc   = (acc << cat) | 64'(extra);
          nbits += cat;
        end
      end
      REQ_FLUSH: begin
        if (nbits > 0) begin
          acc   = (acc << (8 - nbits)) | ((64'h1 << (8 - nbits)) - 64'h1);
          nbits = 8;
        end
      end
      default: ;
    endcase
    if (kind == REQ_ENCODE || kind == REQ_FLUSH) begin
      while (nbits >= 8) begin
        b = 8'(acc >> (nbits - 8));
        nbits -= 8;
        expected_bytes.push_back('{b, 1'b0});
        if (b == BYTE_FF) expected_bytes.push_back('{STUFF_BYTE, 1'b0});
      end
      carry_count = 3'(nbits);
      carry_bits  = 7'(acc & ((64'h1 << nbits) - 64'h1));
    end
    if (expected_bytes.size() > first)
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      carry_bits  = '0;
      carry_count = '0;
      for (int t = 0; t < TABLES; t++) begin
        for (int e = 0; e < ENTRIES; e++) begin
          tab_code[t][e] = '0;
          tab_len[t][e]  = '0;
        end
      end
    end else begin
      // output first: a byte at this edge belongs to an older item
      if (out_tvalid && out_tready) begin
        bytes_checked++;
        if (out_tdata == BYTE_FF) ff_bytes_seen++;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing expected", out_tdata));
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want.data)
            report_mismatch($sformatf("byte %02h, expected %02h", out_tdata, want.data));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last flag %b on byte %02h, expected %b",
                                      out_tlast, out_tdata, want.last));
        end
      end
      if (in_tvalid && in_tready)
        predict_bytes(in_tuser[1:0], in_tuser[2], in_tdata[16:0], in_tdata[21:17],
                      in_tdata[37:22], in_tdata[42:38]);
    end
    bytes_waiting = expected_bytes.size();
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stream test of the huffman bit writer: directed corner items, then random
// tables, differences and flushes under three idle profiles and a long
// receiver hold; the checker predicts and compares every byte
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hbws_pkg::*;

  // request kind the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int ENTRIES      = DEF_MAX_CATEGORY + 1;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 16;    // settle time after the last byte

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [16:0] diff_value, [21:17] entry_index, [37:22] entry_code,
  // [42:38] entry_len, [47:43] zero
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  // [1:0] req_type, [2] table_sel
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] byte_out
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int fail_count;
  int bytes_waiting;
  int bytes_checked;
  int ff_bytes_seen;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // long hold-off of the receiver, started once from the stimulus
  bit   hold_go = 1'b0;
  logic hold_rx = 1'b0;

  // table entries that have been written, so no encode reads an empty one
  bit loaded [2][ENTRIES];

  int n_encode, n_flush, n_load, n_unused;
  int idle_cycles = 0;

  huffman_bit_writer_stuffing DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  hbws_stream_checker stream_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .bytes_waiting (bytes_waiting),
    .bytes_checked (bytes_checked),
    .ff_bytes_seen (ff_bytes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random back-pressure, or held low during the long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_rx) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long hold-off, counted here while the sender keeps offering items
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // watchdog: ends the run when no item moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // random code, often all ones so that 0xff bytes and stuffing show up
  function automatic logic [15:0] rand_code();
    return ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
  endfunction

  // random length, now and then above the 16-bit limit
  function automatic logic [4:0] rand_len();
    return ($urandom_range(7) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
  endfunction

  // offer one item after a random gap and wait for the handshake
  task automatic send_item(input logic [1:0] kind, input logic sel,
                           input logic [16:0] diff, input logic [4:0] idx,
                           input logic [15:0] code, input logic [4:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, len, code, idx, diff};
    in_tuser  <= {sel, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (kind)
      REQ_ENCODE: n_encode++;
      REQ_FLUSH:  n_flush++;
      REQ_LOAD:   n_load++;
      default:    n_unused++;
    endcase
  endtask

  // unused fields of loads, encodes and flushes carry random bits
  task automatic load_entry(input logic sel, input logic [4:0] idx,
                            input logic [15:0] code, input logic [4:0] len);
    send_item(REQ_LOAD, sel, 17'($urandom), idx, code, len);
    // loads past the last category are ignored by the block
    if (idx <= 5'(DEF_MAX_CATEGORY)) loaded[sel][idx] = 1'b1;
  endtask

  // cat is the table entry the value will read; load it first if still empty
  task automatic encode_value(input logic sel, input logic [16:0] diff,
                              input int unsigned cat);
    if (!loaded[sel][cat]) load_entry(sel, 5'(cat), rand_code(), rand_len());
    send_item(REQ_ENCODE, sel, diff, 5'($urandom), 16'($urandom), 5'($urandom));
  endtask

  task automatic send_flush();
    send_item(REQ_FLUSH, 1'($urandom), 17'($urandom), 5'($urandom), 16'($urandom),
              5'($urandom));
  endtask

  // mostly well-formed encode streams, with flushes, table rewrites and noise
  task automatic run_random(input int unsigned count);
    int unsigned pick;
    int unsigned cat;
    logic [16:0] mag;
    logic [16:0] diff;
    logic        sel;
    repeat (count) begin
      pick = $urandom_range(99);
      sel  = 1'($urandom);
      if (pick < 62) begin
        cat = $urandom_range(17);
        if (cat == 17) begin
          // largest negative magnitude
          diff = 17'h10000;
          cat  = 16;
        end else begin
          if (cat == 0) mag = '0;
          else if ($urandom_range(3) == 0) mag = (17'h1 << cat) - 17'd1;
          else mag = (17'h1 << (cat - 1)) | (17'($urandom) & ((17'h1 << (cat - 1)) - 17'd1));
          diff = $urandom_range(1) ? (~mag + 17'd1) : mag;
        end
        encode_value(sel, diff, cat);
      end else if (pick < 75) begin
        send_flush();
      end else if (pick < 88) begin
        load_entry(sel, 5'($urandom_range(16)), rand_code(), rand_len());
      end else if (pick < 94) begin
        load_entry(sel, 5'($urandom_range(31, 17)), rand_code(), rand_len());
      end else begin
        send_item(REQ_UNUSED, sel, 17'($urandom), 5'($urandom), 16'($urandom),
                  5'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender rarely idles, receiver often stalls
    send_idle_pct = 6;
    recv_idle_pct = 58;

    // seven pending ones, then a full 31-bit run of ones: four 0xff bytes,
    // each stuffed, which is the most bytes one item can cause
    load_entry(1'b1, 5'd2, 16'h001F, 5'd5);
    load_entry(1'b0, 5'd15, 16'hFFFF, 5'd16);
    encode_value(1'b1, 17'd3, 2);
    encode_value(1'b0, 17'd32767, 15);
    // flush pads the six ones left to a stuffed 0xff, then an empty flush
    send_flush();
    send_flush();

    // short codes, code bits above the length, saturated length,
    // an empty code, and loads past the last category
    load_entry(1'b0, 5'd0, 16'h0000, 5'd2);
    load_entry(1'b0, 5'd1, 16'hFFFF, 5'd3);
    load_entry(1'b0, 5'd16, 16'hFFFE, 5'd31);
    load_entry(1'b1, 5'd16, 16'h0000, 5'd1);
    load_entry(1'b1, 5'd0, 16'h0000, 5'd0);
    load_entry(1'b0, 5'd31, 16'h1234, 5'd4);
    load_entry(1'b1, 5'd17, 16'hFFFF, 5'd16);

    // extremes of the difference: zero, +-1, +-65535, -65536, -32768
    encode_value(1'b0, 17'd0, 0);
    encode_value(1'b0, 17'd1, 1);
    encode_value(1'b0, 17'h1FFFF, 1);
    encode_value(1'b0, 17'h0FFFF, 16);
    encode_value(1'b0, 17'h10001, 16);
    encode_value(1'b0, 17'h10000, 16);
    encode_value(1'b1, 17'h10000, 16);
    encode_value(1'b1, 17'd0, 0);
    send_item(REQ_UNUSED, 1'b1, 17'h1FFFF, 5'h1F, 16'hFFFF, 5'h1F);
    encode_value(1'b0, 17'h18000, 16);
    send_flush();

    run_random(60);

    // phase two: the other way round
    send_idle_pct = 58;
    recv_idle_pct = 6;
    run_random(55);

    // phase three: no idling, with one long receiver hold so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    run_random(60);
    send_flush();

    in_tvalid <= 1'b0;
    // let the checker see the last accepted item before polling
    @(posedge clk);
    while (bytes_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d encodes, %0d flushes, %0d table loads, %0d unused kinds",
             n_encode, n_flush, n_load, n_unused);
    $display("checked %0d output bytes, %0d of them 0xff, over three idle profiles",
             bytes_checked, ff_bytes_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
